// File: rtl/four_list_vector_sum_search_macros.svh
// ----------------------------------------------------------------------------
// Four-list vector sum search: assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef FOUR_LIST_VECTOR_SUM_SEARCH_MACROS_SVH
`define FOUR_LIST_VECTOR_SUM_SEARCH_MACROS_SVH

// same-cycle implication
`define FLVS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FLVS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/flvs_pkg.sv
// ----------------------------------------------------------------------------
// Four-list vector sum search: package
// Word types, key layout, register indexes, controller states and ops.
// ----------------------------------------------------------------------------
package flvs_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;
    localparam int COORD_W    = 16;
    localparam int SUM_W      = 17;
    localparam int TGT_W      = 18;
    localparam int KIDX_W     = 10;
    localparam int PC_W       = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_X    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_Y    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 2'd2;

    localparam logic [1:0] LIST_A = 2'd0;
    localparam logic [1:0] LIST_D = 2'd3;

    // flipping the sign bit makes unsigned key order match signed order
    localparam logic [SUM_W-1:0] KEY_FLIP = 17'h10000;

    typedef struct packed {
        logic [1:0]                kind;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
    } t_in_word;

    typedef struct packed {
        logic                      found;
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_y;
        logic signed [COORD_W-1:0] b_x;
        logic signed [COORD_W-1:0] b_y;
        logic signed [COORD_W-1:0] c_x;
        logic signed [COORD_W-1:0] c_y;
        logic signed [COORD_W-1:0] d_x;
        logic signed [COORD_W-1:0] d_y;
    } t_out_word;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_point;

    // pair-sum sort key: (x, y, first index, second index)
    typedef struct packed {
        logic [SUM_W-1:0]  kx;
        logic [SUM_W-1:0]  ky;
        logic [KIDX_W-1:0] ki;
        logic [KIDX_W-1:0] kj;
    } t_key;

    typedef enum logic [3:0] {
        S_IDLE, S_BLD_RD, S_BLD_WR, S_SRT_RDE, S_SRT_CAP, S_SRT_RDF, S_SRT_CMP,
        S_SRT_WR, S_SCN_RD, S_SCN_SUM, S_BS_RD, S_BS_CMP, S_SCN_NXT, S_OUT_RD,
        S_OUT_SET, S_OUT_WAIT
    } t_state;

    typedef enum logic [3:0] {
        OP_LOAD, OP_BLD_RD, OP_BLD_WR, OP_SRT_RDE, OP_SRT_CAP, OP_SRT_RDF,
        OP_SRT_CMP, OP_SRT_WR, OP_SCN_RD, OP_SCN_SUM, OP_BS_RD, OP_BS_CMP,
        OP_SCN_NXT, OP_OUT_RD, OP_OUT_SET, OP_OUT_WAIT
    } t_op;

    typedef struct packed {
        logic load_last;
        logic pair_last;
        logic f_last;
        logic e_last;
        logic lr_empty;
        logic hit;
    } t_sts;

endpackage

// File: rtl/flvs_ctrl.sv
// ----------------------------------------------------------------------------
// Four-list vector sum search: controller
// Sequences load, pair build, rank sort, binary search scan and result.
// ----------------------------------------------------------------------------
`include "four_list_vector_sum_search_macros.svh"

module flvs_ctrl
    import flvs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    input  logic i_out_stall,
    output t_op  o_op,
    output logic o_in_stall,
    output logic o_out_valid
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_op        = OP_LOAD;
        o_in_stall  = (r_state != S_IDLE);
        o_out_valid = (r_state == S_OUT_WAIT);
        case (r_state)
            S_IDLE: begin
                o_op = OP_LOAD;
                if (i_sts.load_last) n_state = S_BLD_RD;
            end
            S_BLD_RD: begin
                o_op    = OP_BLD_RD;
                n_state = S_BLD_WR;
            end
            S_BLD_WR: begin
                o_op    = OP_BLD_WR;
                n_state = i_sts.pair_last ? S_SRT_RDE : S_BLD_RD;
            end
            S_SRT_RDE: begin
                o_op    = OP_SRT_RDE;
                n_state = S_SRT_CAP;
            end
            S_SRT_CAP: begin
                o_op    = OP_SRT_CAP;
                n_state = S_SRT_RDF;
            end
            S_SRT_RDF: begin
                o_op    = OP_SRT_RDF;
                n_state = S_SRT_CMP;
            end
            S_SRT_CMP: begin
                o_op    = OP_SRT_CMP;
                n_state = i_sts.f_last ? S_SRT_WR : S_SRT_RDF;
            end
            S_SRT_WR: begin
                o_op    = OP_SRT_WR;
                n_state = i_sts.e_last ? S_SCN_RD : S_SRT_RDE;
            end
            S_SCN_RD: begin
                o_op    = OP_SCN_RD;
                n_state = S_SCN_SUM;
            end
            S_SCN_SUM: begin
                o_op    = OP_SCN_SUM;
                n_state = S_BS_RD;
            end
            S_BS_RD: begin
                o_op    = OP_BS_RD;
                n_state = i_sts.lr_empty ? S_SCN_NXT : S_BS_CMP;
            end
            S_BS_CMP: begin
                o_op    = OP_BS_CMP;
                n_state = i_sts.hit ? S_SCN_NXT : S_BS_RD;
            end
            S_SCN_NXT: begin
                o_op    = OP_SCN_NXT;
                n_state = i_sts.pair_last ? S_OUT_RD : S_SCN_RD;
            end
            S_OUT_RD: begin
                o_op    = OP_OUT_RD;
                n_state = S_OUT_SET;
            end
            S_OUT_SET: begin
                o_op    = OP_OUT_SET;
                n_state = S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
                o_op = OP_OUT_WAIT;
                if (!i_out_stall) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `FLVS_ASSERT_NXT(a_load_starts_build, i_sts.load_last, r_state == S_BLD_RD, "no build")
    `FLVS_ASSERT_IMP(a_busy_while_result, o_out_valid, o_in_stall, "input open with result")
    `FLVS_ASSERT_NXT(a_result_held, o_out_valid && i_out_stall, o_out_valid, "result dropped")

endmodule

// File: rtl/flvs_dp.sv
// ----------------------------------------------------------------------------
// Four-list vector sum search: datapath
// Point lists, pair-sum memories, rank counter, search bounds and best hit.
// ----------------------------------------------------------------------------
`include "four_list_vector_sum_search_macros.svh"

module flvs_dp
    import flvs_pkg::*;
#(
    parameter int MAX_POINTS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_op                   i_op,
    input  logic                  i_in_valid,
    input  t_in_word              i_in_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_sts                  o_sts,
    output t_out_word             o_out_data
);

    localparam int PW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int NW    = $clog2(MAX_POINTS + 1);
    localparam int PAIRS = MAX_POINTS * MAX_POINTS;
    localparam int QW    = $clog2(PAIRS + 1);
    localparam int AW    = (PAIRS > 1) ? $clog2(PAIRS) : 1;

    logic signed [TGT_W-1:0] r_tx, r_ty;
    logic [PC_W-1:0]         r_pc;
    logic [1:0]              r_list;
    logic [PW-1:0]           r_idx;

    logic [NW-1:0]   w_n, w_nm1;
    logic [2*NW-1:0] w_nsq;
    logic            w_match, w_idx_last, w_load_last;

    // effective list length: point_count clamped to 1..MAX_POINTS
    always_comb begin
        if (r_pc == '0) begin
            w_n = NW'(1);
        end else if (32'(r_pc) > MAX_POINTS) begin
            w_n = NW'(MAX_POINTS);
        end else begin
            w_n = NW'(r_pc);
        end
    end
    assign w_nm1 = w_n - NW'(1);
    assign w_nsq = w_n * w_n;

    assign w_match     = (i_op == OP_LOAD) && i_in_valid && (i_in_data.kind == r_list);
    assign w_idx_last  = (NW'(r_idx) == w_nm1);
    assign w_load_last = w_match && (r_list == LIST_D) && w_idx_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx   <= '0;
            r_ty   <= '0;
            r_pc   <= PC_W'(1);
            r_list <= LIST_A;
            r_idx  <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TARGET_X:    r_tx <= i_cfg_data;
                    CFG_TARGET_Y:    r_ty <= i_cfg_data;
                    CFG_POINT_COUNT: r_pc <= i_cfg_data[PC_W-1:0];
                    default: ;
                endcase
            end
            if (i_cfg_we && (i_cfg_idx == CFG_POINT_COUNT)) begin
                r_list <= LIST_A;
                r_idx  <= '0;
            end else if (w_match) begin
                if (w_idx_last) begin
                    r_idx  <= '0;
                    r_list <= r_list + 2'd1;
                end else begin
                    r_idx <= r_idx + PW'(1);
                end
            end
        end
    end

    // ---- point lists: one memory per list, one read port each
    logic [PW-1:0] r_i, r_j;
    t_key          r_best;
    logic [PW-1:0] r_bc, r_bd;
    logic [PW-1:0] w_pt_addr [4];
    t_point        r_pt [4];
    logic          w_out_rd;

    assign w_out_rd = (i_op == OP_OUT_RD);
    always_comb begin
        w_pt_addr[0] = w_out_rd ? r_best.ki[PW-1:0] : r_i;
        w_pt_addr[1] = w_out_rd ? r_best.kj[PW-1:0] : r_j;
        w_pt_addr[2] = w_out_rd ? r_bc : r_i;
        w_pt_addr[3] = w_out_rd ? r_bd : r_j;
    end

    for (genvar g = 0; g < 4; g++) begin : g_list
        t_point mem_pt [MAX_POINTS];
        always_ff @(posedge i_clk) begin
            if (w_match && (r_list == 2'(g))) begin
                mem_pt[r_idx] <= {i_in_data.point_x, i_in_data.point_y};
            end
            r_pt[g] <= mem_pt[w_pt_addr[g]];
        end
    end

    // ---- pair-sum memories: unsorted build and rank-sorted copy
    t_key mem_u [PAIRS];
    t_key mem_s [PAIRS];
    t_key r_u, r_s, r_ke;

    logic [QW-1:0]   r_p, r_e, r_f, r_rank, r_lm1;
    logic [QW:0]     r_lo, r_hi;
    logic [QW+1:0]   w_lh;
    logic [QW-1:0]   w_mid;
    logic [AW-1:0]   w_u_addr;
    logic [SUM_W-1:0] w_cdx, w_cdy, r_x1, r_y1, w_kx2, w_ky2;
    t_key            w_bkey, w_k1;
    logic signed [TGT_W-1:0] w_sx, w_sy;
    logic            r_have, w_pair_last, w_hit;
    t_out_word       r_out;

    assign w_cdx  = {r_pt[2].x[COORD_W-1], r_pt[2].x} + {r_pt[3].x[COORD_W-1], r_pt[3].x};
    assign w_cdy  = {r_pt[2].y[COORD_W-1], r_pt[2].y} + {r_pt[3].y[COORD_W-1], r_pt[3].y};
    assign w_bkey = {w_cdx ^ KEY_FLIP, w_cdy ^ KEY_FLIP, KIDX_W'(r_i), KIDX_W'(r_j)};
    assign w_k1   = {r_x1 ^ KEY_FLIP, r_y1 ^ KEY_FLIP, KIDX_W'(r_i), KIDX_W'(r_j)};

    assign w_lh  = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid = w_lh[QW:1];

    assign w_u_addr = (i_op == OP_SRT_RDE) ? r_e[AW-1:0] : r_f[AW-1:0];

    assign w_kx2 = r_s.kx ^ KEY_FLIP;
    assign w_ky2 = r_s.ky ^ KEY_FLIP;
    assign w_sx  = $signed({r_x1[SUM_W-1], r_x1}) + $signed({w_kx2[SUM_W-1], w_kx2});
    assign w_sy  = $signed({r_y1[SUM_W-1], r_y1}) + $signed({w_ky2[SUM_W-1], w_ky2});
    assign w_hit = (w_sx == r_tx) && (w_sy == r_ty);

    assign w_pair_last = (NW'(r_i) == w_nm1) && (NW'(r_j) == w_nm1);

    always_ff @(posedge i_clk) begin
        if (i_op == OP_BLD_WR) mem_u[r_p[AW-1:0]] <= w_bkey;
        r_u <= mem_u[w_u_addr];
        if (i_op == OP_SRT_WR) mem_s[r_rank[AW-1:0]] <= r_ke;
        r_s <= mem_s[w_mid[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                if (w_load_last) begin
                    r_i    <= '0;
                    r_j    <= '0;
                    r_p    <= '0;
                    r_lm1  <= QW'(w_nsq - (2*NW)'(1));
                    r_have <= 1'b0;
                end
            end
            OP_BLD_WR: begin
                r_p <= r_p + QW'(1);
                if (w_pair_last) begin
                    r_i <= '0;
                    r_j <= '0;
                    r_e <= '0;
                end else if (NW'(r_j) == w_nm1) begin
                    r_j <= '0;
                    r_i <= r_i + PW'(1);
                end else begin
                    r_j <= r_j + PW'(1);
                end
            end
            OP_SRT_CAP: begin
                r_ke   <= r_u;
                r_f    <= '0;
                r_rank <= '0;
            end
            OP_SRT_CMP: begin
                if (r_u < r_ke) r_rank <= r_rank + QW'(1);
                r_f <= r_f + QW'(1);
            end
            OP_SRT_WR: begin
                r_e <= r_e + QW'(1);
            end
            OP_SCN_SUM: begin
                r_x1 <= {r_pt[0].x[COORD_W-1], r_pt[0].x} + {r_pt[1].x[COORD_W-1], r_pt[1].x};
                r_y1 <= {r_pt[0].y[COORD_W-1], r_pt[0].y} + {r_pt[1].y[COORD_W-1], r_pt[1].y};
                r_lo <= '0;
                r_hi <= {1'b0, r_lm1};
            end
            OP_BS_CMP: begin
                if (w_hit) begin
                    // keep the hit with the smallest first-pair key
                    if (!r_have || (w_k1 < r_best)) begin
                        r_have <= 1'b1;
                        r_best <= w_k1;
                        r_bc   <= r_s.ki[PW-1:0];
                        r_bd   <= r_s.kj[PW-1:0];
                    end
                end else if (w_sx > r_tx) begin
                    r_hi <= {1'b0, w_mid} - (QW+1)'(1);
                end else if (w_sx < r_tx) begin
                    r_lo <= {1'b0, w_mid} + (QW+1)'(1);
                end else if (w_sy > r_ty) begin
                    r_hi <= {1'b0, w_mid} - (QW+1)'(1);
                end else begin
                    r_lo <= {1'b0, w_mid} + (QW+1)'(1);
                end
            end
            OP_SCN_NXT: begin
                if (NW'(r_j) == w_nm1) begin
                    r_j <= '0;
                    r_i <= r_i + PW'(1);
                end else begin
                    r_j <= r_j + PW'(1);
                end
            end
            OP_OUT_SET: begin
                r_out.found <= r_have;
                r_out.a_x   <= r_have ? r_pt[0].x : '0;
                r_out.a_y   <= r_have ? r_pt[0].y : '0;
                r_out.b_x   <= r_have ? r_pt[1].x : '0;
                r_out.b_y   <= r_have ? r_pt[1].y : '0;
                r_out.c_x   <= r_have ? r_pt[2].x : '0;
                r_out.c_y   <= r_have ? r_pt[2].y : '0;
                r_out.d_x   <= r_have ? r_pt[3].x : '0;
                r_out.d_y   <= r_have ? r_pt[3].y : '0;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_sts.load_last = w_load_last;
        o_sts.pair_last = w_pair_last;
        o_sts.f_last    = (r_f == r_lm1);
        o_sts.e_last    = (r_e == r_lm1);
        o_sts.lr_empty  = ($signed(r_lo) > $signed(r_hi));
        o_sts.hit       = w_hit;
    end

    assign o_out_data = r_out;

    `FLVS_ASSERT_IMP(a_rank_in_range, i_op == OP_SRT_WR, r_rank <= r_lm1, "rank past last pair")
    `FLVS_ASSERT_IMP(a_bounds_nonneg, i_op == OP_BS_CMP, !r_lo[QW] && !r_hi[QW], "negative bound")
    `FLVS_ASSERT_IMP(a_probe_open, i_op == OP_BS_CMP, !o_sts.lr_empty, "probe on empty range")

endmodule

// File: rtl/four_list_vector_sum_search.sv
// ----------------------------------------------------------------------------
// Four-list vector sum search: top level
// Finds one point from each of four lists whose vector sum hits a target.
// ----------------------------------------------------------------------------
// Load n points into list A, then B, C and D, one word per cycle (a word of
// the wrong list is dropped). The last point of D starts a search during
// which the input stalls: all n*n C+D pair sums are built, rank-sorted
// through one memory read port, then every A+B sum is paired with a binary
// search over the sorted C+D sums, with at most floor(log2(n*n))+1 probes.
// The hit whose A+B key (x, y, i, j) is smallest wins; the result word is
// read from the point lists, registered and held until taken, zeros with
// found=0 when nothing matches. The sort dominates the run time. Write
// registers only while idle; writing point_count restarts the load.
// ----------------------------------------------------------------------------
module four_list_vector_sum_search
    import flvs_pkg::*;
#(
    parameter int MAX_POINTS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // point input
    input  logic                  i_in_valid,
    input  t_in_word              i_in_data,
    output logic                  o_in_stall,
    // result output
    output logic                  o_out_valid,
    output t_out_word             o_out_data,
    input  logic                  i_out_stall,
    // register writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_op  w_op;
    t_sts w_sts;

    // sequencer: one op per cycle to the datapath
    flvs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sts       (w_sts),
        .i_out_stall (i_out_stall),
        .o_op        (w_op),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // storage, sort and search arithmetic
    flvs_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (w_op),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_sts      (w_sts),
        .o_out_data (o_out_data)
    );

endmodule

// File: tb/four_list_vector_sum_search_tb.sv
// ----------------------------------------------------------------------------
// Four-list vector sum search: testbench
// Loads point lists with planted and random quadruples, predicts each search
// result in a local model of the block and checks every result word in order.
// ----------------------------------------------------------------------------
module four_list_vector_sum_search_tb;
    import flvs_pkg::*;

    localparam int NMAX      = 32;
    localparam int SETTLE    = 40;        // idle cycles before a register write
    localparam int CYC_LIMIT = 2000000;
    localparam int HOLD_LEN  = 12000;     // longer than the biggest search used

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    t_in_word              in_data = '0;
    logic                  in_stall;
    logic                  out_valid;
    t_out_word             out_data;
    logic                  out_stall = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = CFG_TARGET_X;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    four_list_vector_sum_search dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // mirror of the block state
    int          tgt_x, tgt_y;
    logic [5:0]  count_reg;
    int          fill;
    int          pt_x [4][NMAX];
    int          pt_y [4][NMAX];
    longint unsigned ab_keys [NMAX*NMAX];
    longint unsigned cd_keys [NMAX*NMAX];

    t_in_word    pending_words [$];
    t_out_word   expected_results [$];
    int          errors = 0;
    int          results_seen = 0;
    int          words_sent = 0;
    bit          calm = 0;        // no idling on either side
    bit          press_req = 0;
    bit          press_done = 0;
    int          src_gap = 0, sink_gap = 0, hold_left = 0;
    int          cycles = 0;

    function automatic int list_len();
        if (count_reg == 0) return 1;
        if (count_reg > NMAX) return NMAX;
        return int'(count_reg);
    endfunction

    // key order: (x, y, i, j), sums offset to stay non-negative
    function automatic longint unsigned sum_key(int sx, int sy, int i, int j);
        return (longint'(sx + 65536) << 42) | (longint'(sy + 65536) << 21) |
               (longint'(i) << 10) | longint'(j);
    endfunction

    function automatic int key_x(longint unsigned k);
        return int'((k >> 42) & 64'h1FFFFF) - 65536;
    endfunction

    function automatic int key_y(longint unsigned k);
        return int'((k >> 21) & 64'h1FFFFF) - 65536;
    endfunction

    function automatic t_out_word find_quadruple();
        int n, len, p, q, l, r, mid, sx, sy, x1, y1;
        int a, b, c, d;
        longint unsigned v;
        t_out_word res;
        n = list_len();
        len = n * n;
        res = '0;
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                ab_keys[i*n+j] = sum_key(pt_x[0][i] + pt_x[1][j], pt_y[0][i] + pt_y[1][j], i, j);
                cd_keys[i*n+j] = sum_key(pt_x[2][i] + pt_x[3][j], pt_y[2][i] + pt_y[3][j], i, j);
            end
        end
        for (p = 1; p < len; p++) begin
            v = ab_keys[p];
            for (q = p; q > 0 && ab_keys[q-1] > v; q--) ab_keys[q] = ab_keys[q-1];
            ab_keys[q] = v;
            v = cd_keys[p];
            for (q = p; q > 0 && cd_keys[q-1] > v; q--) cd_keys[q] = cd_keys[q-1];
            cd_keys[q] = v;
        end
        for (p = 0; p < len; p++) begin
            x1 = key_x(ab_keys[p]);
            y1 = key_y(ab_keys[p]);
            l = 0;
            r = len - 1;
            while (l <= r) begin
                mid = (l + r) / 2;
                sx = x1 + key_x(cd_keys[mid]);
                sy = y1 + key_y(cd_keys[mid]);
                if (sx == tgt_x && sy == tgt_y) begin
                    a = int'((ab_keys[p] >> 10) & 64'h3FF);
                    b = int'(ab_keys[p] & 64'h3FF);
                    c = int'((cd_keys[mid] >> 10) & 64'h3FF);
                    d = int'(cd_keys[mid] & 64'h3FF);
                    res.found = 1'b1;
                    res.a_x = 16'(pt_x[0][a]); res.a_y = 16'(pt_y[0][a]);
                    res.b_x = 16'(pt_x[1][b]); res.b_y = 16'(pt_y[1][b]);
                    res.c_x = 16'(pt_x[2][c]); res.c_y = 16'(pt_y[2][c]);
                    res.d_x = 16'(pt_x[3][d]); res.d_y = 16'(pt_y[3][d]);
                    return res;
                end
                if (sx > tgt_x) r = mid - 1;
                else if (sx < tgt_x) l = mid + 1;
                else if (sy > tgt_y) r = mid - 1;
                else l = mid + 1;
            end
        end
        return res;
    endfunction

    // one accepted point: store it, search when the last D point lands
    function automatic void load_point(t_in_word w);
        int n, lst, idx;
        n = list_len();
        lst = fill / n;
        idx = fill % n;
        if (lst > 3) begin
            fill = 0; lst = 0; idx = 0;
        end
        if (int'(w.kind) != lst) return;
        pt_x[lst][idx] = int'(w.point_x);
        pt_y[lst][idx] = int'(w.point_y);
        fill++;
        if (fill < 4 * n) return;
        fill = 0;
        expected_results.push_back(find_quadruple());
    endfunction

    task automatic report(string field, int got, int want);
        errors++;
        $display("MISMATCH result %0d %s: got %0d expected %0d", results_seen, field, got, want);
    endtask

    // driver: one word in flight, random gaps after a word goes out
    always @(posedge i_clk) begin
        bit busy;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            busy = in_valid;
            if (in_valid && !in_stall) begin
                load_point(in_data);
                busy = 0;
            end
            if (!busy) begin
                if (src_gap > 0) begin
                    src_gap--;
                    in_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    in_valid <= 1'b1;
                    in_data <= pending_words.pop_front();
                    words_sent++;
                    if (!calm && $urandom_range(0, 9) == 0) src_gap = $urandom_range(1, 7);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall: random bursts, plus one long hold to back up the block;
    // the hold starts mid-search with a word waiting, so the result is caught
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (press_req && !press_done && in_valid && in_stall && !out_valid) begin
                press_done = 1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (sink_gap > 0) begin
                sink_gap--;
                out_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                sink_gap = $urandom_range(0, 6);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // monitor: compare each result word with the oldest prediction
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                report("unexpected word", 1, 0);
            end else begin
                want = expected_results.pop_front();
                if (out_data.found !== want.found)
                    report("found", int'(out_data.found), int'(want.found));
                if (out_data.a_x !== want.a_x) report("a_x", int'(out_data.a_x), int'(want.a_x));
                if (out_data.a_y !== want.a_y) report("a_y", int'(out_data.a_y), int'(want.a_y));
                if (out_data.b_x !== want.b_x) report("b_x", int'(out_data.b_x), int'(want.b_x));
                if (out_data.b_y !== want.b_y) report("b_y", int'(out_data.b_y), int'(want.b_y));
                if (out_data.c_x !== want.c_x) report("c_x", int'(out_data.c_x), int'(want.c_x));
                if (out_data.c_y !== want.c_y) report("c_y", int'(out_data.c_y), int'(want.c_y));
                if (out_data.d_x !== want.d_x) report("d_x", int'(out_data.d_x), int'(want.d_x));
                if (out_data.d_y !== want.d_y) report("d_y", int'(out_data.d_y), int'(want.d_y));
            end
            results_seen++;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYC_LIMIT) begin
            $display("timeout with %0d results outstanding", expected_results.size());
            $display("four_list_vector_sum_search test failed");
            $finish;
        end
    end

    // wait until every word went in, every result came out, then a pause
    task automatic settle();
        @(negedge i_clk);
        while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
            @(negedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_TARGET_X: tgt_x = value;
            CFG_TARGET_Y: tgt_y = value;
            CFG_POINT_COUNT: begin
                count_reg = value[5:0];
                fill = 0;
            end
            default: ;
        endcase
    endtask

    task automatic push_point(int kind, int x, int y);
        t_in_word w;
        w.kind = kind[1:0];
        w.point_x = x[15:0];
        w.point_y = y[15:0];
        pending_words.push_back(w);
    endtask

    function automatic int rand_coord(int span);
        if (span >= 32768) return int'($signed(16'($urandom)));
        return $urandom_range(0, 2 * span) - span;
    endfunction

    // one full load; optionally plants a quadruple that hits the target,
    // and sprinkles words of the wrong list in between
    task automatic push_load(int span, bit plant, int noise_pct);
        int n, dx, dy;
        int lx [4][NMAX];
        int ly [4][NMAX];
        int pick [4];
        n = list_len();
        for (int l = 0; l < 4; l++) begin
            pick[l] = $urandom_range(0, n - 1);
            for (int k = 0; k < n; k++) begin
                lx[l][k] = rand_coord(span);
                ly[l][k] = rand_coord(span);
            end
        end
        if (plant) begin
            dx = tgt_x - lx[0][pick[0]] - lx[1][pick[1]] - lx[2][pick[2]];
            dy = tgt_y - ly[0][pick[0]] - ly[1][pick[1]] - ly[2][pick[2]];
            if (dx >= -32768 && dx <= 32767 && dy >= -32768 && dy <= 32767) begin
                lx[3][pick[3]] = dx;
                ly[3][pick[3]] = dy;
            end
        end
        for (int l = 0; l < 4; l++) begin
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(0, 99) < noise_pct)
                    push_point((l + $urandom_range(1, 3)) % 4, rand_coord(32768),
                               rand_coord(32768));
                push_point(l, lx[l][k], ly[l][k]);
            end
        end
    endtask

    initial begin
        int n, span, sets;
        tgt_x = 0;
        tgt_y = 0;
        count_reg = 6'd1;
        fill = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings, zero points hit target zero
        for (int l = 0; l < 4; l++) push_point(l, 0, 0);
        // wrong list words are dropped
        push_point(2, 5, 5);
        for (int l = 0; l < 4; l++) push_point(l, 1, -1);
        settle();
        // most negative corner reaches the most negative target
        write_reg(CFG_TARGET_X, -131072);
        write_reg(CFG_TARGET_Y, -131072);
        write_reg(CFG_POINT_COUNT, 0);        // clamps to one point per list
        for (int l = 0; l < 4; l++) push_point(l, -32768, -32768);
        for (int l = 0; l < 4; l++) push_point(l, 32767, 32767);
        settle();
        write_reg(CFG_TARGET_X, 131071);
        write_reg(CFG_TARGET_Y, 131068);
        write_reg(CFG_POINT_COUNT, 2);
        for (int l = 0; l < 4; l++) begin
            push_point(l, 32767, 32767);
            push_point(l, 32767, 32767);
        end
        settle();
        // oversized count clamps; a partial load is dropped by a rewrite
        write_reg(CFG_POINT_COUNT, 63);
        for (int k = 0; k < 5; k++) push_point(0, k, k);
        settle();
        write_reg(CFG_TARGET_X, 0);
        write_reg(CFG_TARGET_Y, 0);
        write_reg(CFG_POINT_COUNT, 1);
        for (int l = 0; l < 4; l++) push_point(l, l - 2, 2 - l);
        settle();

        // random part: mostly planted loads, some plain and noisy ones
        press_req = 1;
        while (words_sent < 1000) begin
            if (words_sent > 800) calm = 1;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
            case ($urandom_range(0, 2))
                0: span = 3;
                1: span = 8000;
                default: span = 32768;
            endcase
            write_reg(CFG_POINT_COUNT, n);
            write_reg(CFG_TARGET_X, (span == 32768) ? $urandom_range(0, 262143) - 131072
                                                    : $urandom_range(0, 40000) - 20000);
            write_reg(CFG_TARGET_Y, (span == 3) ? $urandom_range(0, 12) - 6
                                                : $urandom_range(0, 40000) - 20000);
            sets = (n > 4) ? 1 : $urandom_range(2, 6);
            for (int s = 0; s < sets; s++)
                push_load(span, $urandom_range(0, 9) < 7, ($urandom_range(0, 3) == 0) ? 15 : 0);
            settle();
        end

        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("four_list_vector_sum_search test passed");
        end else begin
            $display("four_list_vector_sum_search test failed");
        end
        $finish;
    end

endmodule
